FILE: rtl/core/sha1_pkg.sv
// Shared types and constants of the SHA-1 hash core.
`default_nettype none
package sha1_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FINAL,
		ST_OUT
	} state_t;

	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [2:0] WORD_LAST = 3'd4;

endpackage
`default_nettype wire

FILE: rtl/core/sha1_hash_core_unit.sv
// SHA-1 hash core: byte-wide message in, five-word digest out.
// Message bytes are taken one per cycle, while the port is ready, into a
// 512-bit block shift line. When 64 bytes are held the block is compressed
// by one shared round unit, one round per cycle, followed by the chaining add;
// the message port is not ready during the rounds and the chaining add. On
// the end mark the padding (0x80, zeros, 64-bit big-endian bit length) is
// shifted in one byte per cycle, followed by one or two compressions, and the
// digest then leaves as five words, most significant first, one per
// transfer. The port accepts again after the fifth word, starting afresh
// from the initial values.
`default_nettype none
module sha1_hash_core_unit
	import sha1_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    msg_valid,
	output logic         msg_ready,
	input  wire msg_t    msg,
	output logic         digest_valid,
	input  wire logic    digest_ready,
	output digest_t      digest
);

	state_t      state_q, state_d;
	logic [511:0] blk_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        pend_q, sent80_q, len_blk_q, final_q;

	logic        in_xfer, out_xfer;
	logic [7:0]  pad_byte;
	logic [7:0]  len_byte;
	logic [31:0] w0, w2, w8, w13, wmix, wnew;
	logic [31:0] f_val, k_val, t_val;

	assign in_xfer  = msg_valid && msg_ready;
	assign out_xfer = digest_valid && digest_ready;

	// Length bytes go out most significant first at positions 56..63.
	assign len_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		if (!sent80_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_blk_q && fill_q >= LEN_POS) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Schedule window: the oldest word sits in the top bits.
	assign w0   = blk_q[511:480];
	assign w2   = blk_q[447:416];
	assign w8   = blk_q[255:224];
	assign w13  = blk_q[95:64];
	assign wmix = w13 ^ w8 ^ w2 ^ w0;
	assign wnew = {wmix[30:0], wmix[31]};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_R0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (msg.has_byte && fill_q == FILL_LAST) begin
						state_d = ST_COMP;
					end else if (msg.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == FILL_LAST) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (pend_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_xfer && idx_q == WORD_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		msg_ready    = 1'b0;
		digest_valid = 1'b0;
		unique case (state_q)
			ST_IDLE:  msg_ready    = 1'b1;
			ST_OUT:   digest_valid = 1'b1;
			default: begin
				msg_ready    = 1'b0;
				digest_valid = 1'b0;
			end
		endcase
	end

	assign digest.digest_word = h_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == WORD_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			bits_q    <= '0;
			rnd_q     <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			sent80_q  <= 1'b0;
			len_blk_q <= 1'b0;
			final_q   <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= SHA1_IV[i];
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						pend_q    <= msg.end_of_message;
						sent80_q  <= 1'b0;
						len_blk_q <= 1'b0;
						final_q   <= 1'b0;
						if (msg.has_byte) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						rnd_q <= '0;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (!sent80_q) begin
						sent80_q  <= 1'b1;
						len_blk_q <= (fill_q < LEN_POS);
					end
					if (fill_q == FILL_LAST) begin
						final_q <= sent80_q && len_blk_q;
					end
					rnd_q <= '0;
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
				end
				ST_FINAL: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					// second padding block carries the length
					if (!final_q && pend_q) begin
						len_blk_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_xfer) begin
						if (idx_q == WORD_LAST) begin
							idx_q  <= '0;
							bits_q <= '0;
							pend_q <= 1'b0;
							for (int i = 0; i < 5; i++) begin
								h_q[i] <= SHA1_IV[i];
							end
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					idx_q <= '0;
				end
			endcase
		end
	end

	// Block shift line and working words: payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer && msg.has_byte) begin
			blk_q <= {blk_q[503:0], msg.data_byte};
		end else if (state_q == ST_PAD) begin
			blk_q <= {blk_q[503:0], pad_byte};
		end else if (state_q == ST_COMP) begin
			blk_q <= {blk_q[479:0], wnew};
		end

		if (state_q == ST_COMP) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end else begin
			// load the chaining words ahead of the first round
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sha1_chk.sv
// Port-level checks of the SHA-1 hash core, bound to its top level.
`default_nettype none
module sha1_chk
	import sha1_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    msg_ready,
	input wire logic    digest_valid,
	input wire logic    digest_ready,
	input wire digest_t digest
);

	// hold a stalled digest word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest))
		else $error("digest changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && digest_valid))
		else $error("message taken while digest pending");

	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !digest.last_word |=>
		digest_valid && digest.word_index == $past(digest.word_index) + 3'd1)
		else $error("digest words out of sequence");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && digest.last_word |=> !digest_valid && msg_ready)
		else $error("digest continued after last word");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> digest.last_word == (digest.word_index == WORD_LAST))
		else $error("last word flag mismatch");

endmodule

bind sha1_hash_core_unit sha1_chk u_sha1_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_ready    (msg_ready),
	.digest_valid (digest_valid),
	.digest_ready (digest_ready),
	.digest       (digest)
);
`default_nettype wire

FILE: tb/sha1_hash_core_unit_tb.sv
// Self-checking testbench for the byte-wide SHA-1 hash core.
module sha1_hash_core_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sha1_pkg::*;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    msg_valid = 1'b0;
	logic    msg_ready;
	msg_t    msg = '0;
	logic    digest_valid;
	logic    digest_ready = 1'b0;
	digest_t digest;

	int sender_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int errors = 0;

	// Predicted hash state
	logic [31:0] hash_state [5];
	logic [7:0]  block_bytes [64];
	int          block_fill;
	logic [63:0] message_bits;
	digest_t     expected_digest_q [$];

	sha1_hash_core_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg(msg),
		.digest_valid(digest_valid),
		.digest_ready(digest_ready),
		.digest(digest)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void restart_hash();
		hash_state = SHA1_IV;
		block_fill = 0;
		message_bits = '0;
	endfunction

	// Fold the buffered block into the chaining words: 80 rounds
	function automatic void fold_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
		for (int r = 16; r < 80; r++)
			w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = rotl(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	// Advance the predicted hash by one accepted message transfer
	function automatic void absorb_item(input msg_t m);
		digest_t dw;
		int pos;
		if (m.has_byte) begin
			block_bytes[block_fill] = m.data_byte;
			message_bits += 64'd8;
			if (block_fill == int'(FILL_LAST)) begin
				fold_block();
				block_fill = 0;
			end else begin
				block_fill++;
			end
		end
		if (m.end_of_message) begin
			block_bytes[block_fill] = PAD_BYTE;
			pos = block_fill + 1;
			// no room for the length: pad out and use a second block
			if (pos > int'(LEN_POS)) begin
				for (int i = pos; i < 64; i++)
					block_bytes[i] = 8'h00;
				fold_block();
				pos = 0;
			end
			for (int i = pos; i < int'(LEN_POS); i++)
				block_bytes[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				block_bytes[int'(LEN_POS) + i] = message_bits[63 - 8*i -: 8];
			fold_block();
			for (int i = 0; i < 5; i++) begin
				dw.digest_word = hash_state[i];
				dw.word_index = 3'(i);
				dw.last_word = (3'(i) == WORD_LAST);
				expected_digest_q.push_back(dw);
			end
			restart_hash();
		end
	endfunction

	task automatic send_item(input msg_t m);
		if ($urandom_range(99) < sender_idle_pct) begin
			msg_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= m;
		do @(posedge clk); while (!msg_ready);
		absorb_item(m);
		if (m.has_byte || m.end_of_message)
			items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] value, input logic last);
		msg_t m;
		m.data_byte = value;
		m.has_byte = 1'b1;
		m.end_of_message = last;
		send_item(m);
	endtask

	task automatic send_bare(input logic last);
		msg_t m;
		m.data_byte = 8'($urandom);
		m.has_byte = 1'b0;
		m.end_of_message = last;
		send_item(m);
	endtask

	// Random bytes; the end rides on the last byte or comes bare
	task automatic send_message(input int len);
		logic end_on_byte;
		end_on_byte = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				send_bare(1'b0);
			send_byte(8'($urandom), end_on_byte && (i == len - 1));
		end
		if (!end_on_byte)
			send_bare(1'b1);
	endtask

	task automatic test_empty_message();
		send_bare(1'b1);
	endtask

	task automatic test_byte_with_end();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_abc();
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b1);
	endtask

	task automatic test_idle_and_bare_end();
		send_bare(1'b0);
		send_byte(8'hFF, 1'b0);
		send_bare(1'b0);
		send_byte(8'h00, 1'b0);
		send_bare(1'b0);
		send_byte(8'hA5, 1'b0);
		send_bare(1'b1);
	endtask

	task automatic test_random_messages(input int budget, input int boundary_len);
		int stop_at;
		int r;
		stop_at = items_sent + budget;
		// one message sized around the padding boundary
		send_message(boundary_len);
		while (items_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 15)
				send_message(0);
			else if (r < 80)
				send_message($urandom_range(1, 12));
			else
				send_message($urandom_range(13, 40));
		end
	endtask

	// Digest side: check each transfer, then pick the next ready
	always @(posedge clk) begin
		digest_t want;
		if (digest_valid && digest_ready) begin
			if (expected_digest_q.size() == 0) begin
				$display("%t unexpected digest transfer: got %h", $time, digest);
				errors++;
			end else begin
				want = expected_digest_q.pop_front();
				if (digest.digest_word !== want.digest_word) begin
					$display("%t digest_word: expected %h, got %h", $time,
						want.digest_word, digest.digest_word);
					errors++;
				end
				if (digest.word_index !== want.word_index) begin
					$display("%t word_index: expected %0d, got %0d", $time,
						want.word_index, digest.word_index);
					errors++;
				end
				if (digest.last_word !== want.last_word) begin
					$display("%t last_word: expected %b, got %b", $time,
						want.last_word, digest.last_word);
					errors++;
				end
			end
		end
		digest_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		restart_hash();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 15;
		recv_idle_pct = 58;
		test_empty_message();
		test_byte_with_end();
		test_abc();
		test_idle_and_bare_end();
		test_random_messages(90, 55);

		sender_idle_pct = 58;
		recv_idle_pct = 15;
		test_random_messages(90, 56);

		sender_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_messages(90, 64);

		msg_valid <= 1'b0;
		while (expected_digest_q.size() != 0)
			@(posedge clk);
		// hold for any stray transfer after the last digest
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("sha1_hash_core_unit_tb: PASS");
		else
			$display("sha1_hash_core_unit_tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("sha1_hash_core_unit_tb: FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_hash_core_unit.sv
rtl/core/sha1_chk.sv
tb/sha1_hash_core_unit_tb.sv
